// ===== hw/rtl/oes_pkg.sv =====
// Shared types and constants for the octal escape sanitizer.
// Holds the word structs, character codes, hold-state codes and queue sizing.
// No dependencies.
package oes_pkg;

	// Character codes the scanner looks for.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG3   = 8'h33;
	localparam logic [7:0] CH_DIG7   = 8'h37;

	// What the scanner is holding between words.
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_BS   = 2'd1;
	localparam logic [1:0] PEND_D1   = 2'd2;
	localparam logic [1:0] PEND_D2   = 2'd3;

	// One input word may release up to four output words.
	localparam int BurstMax = 4;
	localparam int BurstCw  = 3;

	// Output queue sizing.
	localparam int FifoDepth = 8;
	localparam int FifoAw    = 3;
	localparam int FifoCw    = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	// Words released by one input word, in order, and how many are valid.
	typedef struct packed {
		logic [BurstCw-1:0]           cnt;
		out_word_t [BurstMax-1:0]     words;
	} burst_t;

endpackage

// ===== hw/rtl/oes_step.sv =====
// Combinational scan step of the octal escape sanitizer.
// Given the held state and one input word, produces the released words
// and the next held state. Depends on oes_pkg.
module oes_step import oes_pkg::*; (
	input  logic [1:0] pend,
	input  logic [7:0] held0,
	input  logic [7:0] held1,
	input  in_word_t   word,
	output logic [1:0] pend_nxt,
	output logic [7:0] held0_nxt,
	output logic [7:0] held1_nxt,
	output burst_t     burst
);

	logic               is_bs;
	logic               d03;
	logic               d07;
	logic               last;
	logic [7:0]         b;
	logic               do_fresh;
	logic [BurstCw-1:0] n;

	assign b     = word.in_byte;
	assign last  = word.in_last;
	assign is_bs = (b == CH_BSLASH);
	assign d03   = (b >= CH_DIG0) && (b <= CH_DIG3);
	assign d07   = (b >= CH_DIG0) && (b <= CH_DIG7);

	// Decide what the held bytes become, then examine the current byte afresh
	// when the held escape was rejected.
	always_comb begin
		burst     = '0;
		pend_nxt  = pend;
		held0_nxt = held0;
		held1_nxt = held1;
		do_fresh  = 1'b0;
		n         = '0;
		case (pend)
			PEND_NONE: begin
				do_fresh = 1'b1;
			end
			PEND_BS: begin
				if (is_bs) begin
					burst.words[0].out_byte = CH_BSLASH;
					burst.words[1].out_byte = CH_BSLASH;
					n        = 3'd2;
					pend_nxt = PEND_NONE;
				end else if (d03 && !last) begin
					held0_nxt = b;
					pend_nxt  = PEND_D1;
				end else begin
					burst.words[0].out_byte = CH_SPACE;
					n        = 3'd1;
					pend_nxt = PEND_NONE;
					do_fresh = 1'b1;
				end
			end
			PEND_D1: begin
				if (d07 && !last) begin
					held1_nxt = b;
					pend_nxt  = PEND_D2;
				end else begin
					burst.words[0].out_byte = CH_SPACE;
					burst.words[1].out_byte = held0;
					n        = 3'd2;
					pend_nxt = PEND_NONE;
					do_fresh = 1'b1;
				end
			end
			default: begin
				pend_nxt = PEND_NONE;
				if (d07) begin
					burst.words[0].out_byte = CH_BSLASH;
					burst.words[1].out_byte = held0;
					burst.words[2].out_byte = held1;
					burst.words[3].out_byte = b;
					n = 3'd4;
				end else begin
					burst.words[0].out_byte = CH_SPACE;
					burst.words[1].out_byte = held0;
					burst.words[2].out_byte = held1;
					n        = 3'd3;
					do_fresh = 1'b1;
				end
			end
		endcase

		// A fresh backslash is held unless it ends the string, where it
		// turns into a space; any other byte passes unchanged.
		if (do_fresh) begin
			if (is_bs && !last) begin
				pend_nxt = PEND_BS;
			end else begin
				burst.words[n[1:0]].out_byte = is_bs ? CH_SPACE : b;
				n = n + 3'd1;
			end
		end

		// The final released word of the string carries the end mark.
		for (int i = 0; i < BurstMax; i++) begin
			burst.words[i].out_last = last && ((BurstCw'(i) + 3'd1) == n);
		end
		burst.cnt = n;
	end

endmodule

// ===== hw/rtl/octal_escape_sanitizer_unit.sv =====
// Octal escape sanitizer: replaces backslashes that start no valid escape.
// One input register stage, one scan step and an eight-word output queue.
// Uses the input channel src_* and the output channel dst_*.
//
// Each input word carries one byte and a flag on the final byte of a string.
// Output words come out in order; a backslash that is followed neither by a
// second backslash nor by three octal digits (first 0-3) becomes a space.
// A backslash and up to two digits are held until the escape is decided, so
// one input word releases zero to four output words.
//
// An input word is taken at each edge with src_valid high and src_stall low.
// It is registered in the input register, and when the stage advances its
// released words enter the output queue, the first of them showing on dst_*
// at once if the queue was empty. The queue drains one word per cycle while
// dst_stall is low, and an input word can be taken every cycle while src_stall
// is low. Held bytes plus queued words never exceed four while the receiver
// keeps dst_stall low, so the input then never stalls; src_stall rises only
// when dst_stall has let the queue fill past four words, and it falls as the
// queue drains. Reset empties the queue and clears the input valid flag and
// the held escape state; the block takes words as soon as reset is released.
module octal_escape_sanitizer_unit import oes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_word_t  src_word,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_word_t dst_word
);

	logic                 vld_s1;
	in_word_t             word_s1;
	logic [1:0]           pend_q;
	logic [7:0]           held0_q;
	logic [7:0]           held1_q;
	logic [1:0]           pend_nxt;
	logic [7:0]           held0_nxt;
	logic [7:0]           held1_nxt;
	burst_t               burst;
	out_word_t            fifo_q [FifoDepth];
	logic [FifoAw-1:0]    wr_ptr_q;
	logic [FifoAw-1:0]    rd_ptr_q;
	logic [FifoCw-1:0]    cnt_q;
	logic                 adv;
	logic                 pop;
	logic [BurstCw-1:0]   push_cnt;

	// The stage word moves into the queue once room for a full burst exists.
	assign adv       = vld_s1 && (cnt_q <= FifoCw'(FifoDepth - BurstMax));
	assign src_stall = vld_s1 && !adv;
	assign pop       = dst_valid && !dst_stall;
	assign push_cnt  = adv ? burst.cnt : '0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall) begin
			word_s1 <= src_word;
		end
	end

	oes_step u_step (
		.pend      (pend_q),
		.held0     (held0_q),
		.held1     (held1_q),
		.word      (word_s1),
		.pend_nxt  (pend_nxt),
		.held0_nxt (held0_nxt),
		.held1_nxt (held1_nxt),
		.burst     (burst)
	);

	// Held escape state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
		end else if (adv) begin
			pend_q <= pend_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			held0_q <= held0_nxt;
			held1_q <= held1_nxt;
		end
	end

	// Output queue storage: up to four words written per cycle.
	always_ff @(posedge clk) begin
		for (int i = 0; i < BurstMax; i++) begin
			if (BurstCw'(i) < push_cnt) begin
				fifo_q[wr_ptr_q + FifoAw'(i)] <= burst.words[i];
			end
		end
	end

	// Output queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FifoAw'(push_cnt);
			rd_ptr_q <= rd_ptr_q + FifoAw'(pop);
			cnt_q    <= cnt_q + FifoCw'(push_cnt) - FifoCw'(pop);
		end
	end

	assign dst_valid = (cnt_q != '0);
	assign dst_word  = fifo_q[rd_ptr_q];

endmodule

// ===== hw/rtl/oes_checker.sv =====
// Port-level checker for the octal escape sanitizer, bound to the top level.
// Watches only the top-level ports. Depends on oes_pkg.
module oes_checker import oes_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input in_word_t  src_word,
	input logic      dst_valid,
	input logic      dst_stall,
	input out_word_t dst_word
);

	// A stalled output word stays offered.
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid)
		else $error("output word withdrawn while stalled");

	// A stalled output word keeps its value.
	a_dst_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> $stable(dst_word))
		else $error("output word changed while stalled");

	// The input only stalls while the output queue has words to give.
	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid)
		else $error("input stalled with the output queue empty");

	// Output from an empty queue traces back to an accepted input word.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(src_valid && !src_stall, 2))
		else $error("output word appeared without an input word");

endmodule

bind octal_escape_sanitizer_unit oes_checker u_oes_checker (.*);

// ===== test/tb_octal_escape_sanitizer_unit.sv =====
// Self-checking testbench for octal_escape_sanitizer_unit: directed strings, then random strings.
// It predicts the sanitized words itself and checks every output word in order.
// Depends on oes_pkg and the octal_escape_sanitizer_unit RTL.
module tb_octal_escape_sanitizer_unit;
	import oes_pkg::*;

	localparam int NumDirected = 26;
	localparam int PhaseItems  = 105;

	// One row of the directed table. The first expected byte sits in exp_bytes[31:24].
	typedef struct packed {
		logic [7:0]  in_byte;
		logic        in_last;
		logic        typed;
		logic [2:0]  exp_cnt;
		logic [31:0] exp_bytes;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_word_t  src_word = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_word_t dst_word;

	// Predictor state: what is held between words.
	logic [1:0] hold_state;
	logic [7:0] held_dig [2];
	out_word_t  released [$];
	out_word_t  sanitized_q [$];
	logic [7:0] str_bytes [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_fail = 0;
	int n_items = 0;
	int n_words = 0;
	int n_strings = 0;
	int n_kept_esc = 0;
	int n_replaced = 0;
	int n_drains = 0;

	dir_row_t dir_tab [NumDirected];

	octal_escape_sanitizer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#3200000;
		$display("tb_octal_escape_sanitizer_unit: FAIL");
		$finish;
	end

	function automatic void emit(input logic [7:0] b);
		out_word_t w;
		w.out_byte = b;
		w.out_last = 1'b0;
		released.push_back(w);
	endfunction

	// A byte looked at with nothing held.
	function automatic void take_fresh(input logic [7:0] b, input logic lst);
		if (b == CH_BSLASH) begin
			if (lst) begin
				emit(CH_SPACE);
				n_replaced++;
			end else begin
				hold_state = PEND_BS;
			end
		end else begin
			emit(b);
		end
	endfunction

	// Works out the words released by one input word and updates the held state.
	function automatic void sanitize_byte(input in_word_t w);
		logic [7:0] b;
		logic       lst;
		logic       oct_lo;
		logic       oct_any;
		out_word_t  tail;
		b = w.in_byte;
		lst = w.in_last;
		oct_lo = (b >= CH_DIG0) && (b <= CH_DIG3);
		oct_any = (b >= CH_DIG0) && (b <= CH_DIG7);
		released.delete();
		case (hold_state)
			PEND_NONE: begin
				take_fresh(b, lst);
			end
			PEND_BS: begin
				if (b == CH_BSLASH) begin
					hold_state = PEND_NONE;
					emit(CH_BSLASH);
					emit(CH_BSLASH);
					n_kept_esc++;
				end else if (oct_lo && !lst) begin
					held_dig[0] = b;
					hold_state = PEND_D1;
				end else begin
					hold_state = PEND_NONE;
					emit(CH_SPACE);
					n_replaced++;
					take_fresh(b, lst);
				end
			end
			PEND_D1: begin
				if (oct_any && !lst) begin
					held_dig[1] = b;
					hold_state = PEND_D2;
				end else begin
					hold_state = PEND_NONE;
					emit(CH_SPACE);
					emit(held_dig[0]);
					n_replaced++;
					take_fresh(b, lst);
				end
			end
			default: begin
				hold_state = PEND_NONE;
				if (oct_any) begin
					emit(CH_BSLASH);
					emit(held_dig[0]);
					emit(held_dig[1]);
					emit(b);
					n_kept_esc++;
				end else begin
					emit(CH_SPACE);
					emit(held_dig[0]);
					emit(held_dig[1]);
					n_replaced++;
					take_fresh(b, lst);
				end
			end
		endcase
		// The final released word of a string carries the last flag.
		if (lst && released.size() > 0) begin
			tail = released.pop_back();
			tail.out_last = 1'b1;
			released.push_back(tail);
		end
	endfunction

	// Offers one word, idling first at random, and predicts its output once taken.
	task automatic send_word(input in_word_t w);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= w;
		do @(posedge clk); while (src_stall);
		sanitize_byte(w);
		n_items++;
	endtask

	task automatic queue_released();
		while (released.size() > 0) sanitized_q.push_back(released.pop_front());
	endtask

	// Holds the input off until every predicted word has come out.
	task automatic drain_wait();
		src_valid <= 1'b0;
		do @(posedge clk); while (sanitized_q.size() != 0);
		n_drains++;
	endtask

	// Builds a string of random pieces: plain bytes, escapes, pairs and broken escapes.
	task automatic build_string();
		int pieces;
		int kind;
		int ndig;
		str_bytes.delete();
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				str_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 6) begin
				str_bytes.push_back(CH_BSLASH);
				str_bytes.push_back(CH_DIG0 + 8'($urandom_range(0, 3)));
				str_bytes.push_back(CH_DIG0 + 8'($urandom_range(0, 7)));
				str_bytes.push_back(CH_DIG0 + 8'($urandom_range(0, 7)));
			end else if (kind == 6) begin
				str_bytes.push_back(CH_BSLASH);
				str_bytes.push_back(CH_BSLASH);
			end else if (kind < 9) begin
				// Backslash, zero to two digits, then a byte that may or may not fit.
				str_bytes.push_back(CH_BSLASH);
				ndig = $urandom_range(0, 2);
				repeat (ndig) str_bytes.push_back(CH_DIG0 + 8'($urandom_range(0, 7)));
				if ($urandom_range(0, 1))
					str_bytes.push_back(CH_DIG0 + 8'($urandom_range(0, 9)));
				else
					str_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				str_bytes.push_back(CH_BSLASH);
			end
		end
	endtask

	// Output checker and receiver stall.
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			n_words++;
			if (sanitized_q.size() == 0) begin
				$display("%0t: unexpected word byte=%h last=%b", $time,
					dst_word.out_byte, dst_word.out_last);
				n_fail++;
			end else begin
				if (dst_word.out_byte !== sanitized_q[0].out_byte) begin
					$display("%0t: out_byte expected %h actual %h", $time,
						sanitized_q[0].out_byte, dst_word.out_byte);
					n_fail++;
				end
				if (dst_word.out_last !== sanitized_q[0].out_last) begin
					$display("%0t: out_last expected %b actual %b", $time,
						sanitized_q[0].out_last, dst_word.out_last);
					n_fail++;
				end
				void'(sanitized_q.pop_front());
			end
		end
		dst_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Main stimulus.
	initial begin
		in_word_t  w;
		out_word_t ow;
		int        i;
		int        k;
		int        ph;
		int        start_items;

		// Directed rows: byte, last, typed, count, expected bytes.
		dir_tab = '{
			'{8'h41,     1'b0, 1'b1, 3'd1, 32'h41000000},
			'{8'h00,     1'b0, 1'b1, 3'd1, 32'h00000000},
			'{8'hFF,     1'b0, 1'b1, 3'd1, 32'hFF000000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd2, 32'h5C5C0000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_DIG3,   1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_DIG7,   1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_DIG7,   1'b0, 1'b1, 3'd4, 32'h5C333737},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_DIG0,   1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_DIG0,   1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h38,     1'b0, 1'b0, 3'd0, 32'h00000000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h34,     1'b0, 1'b1, 3'd2, 32'h20340000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h31,     1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h39,     1'b0, 1'b0, 3'd0, 32'h00000000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h32,     1'b0, 1'b1, 3'd0, 32'h00000000},
			'{CH_BSLASH, 1'b0, 1'b0, 3'd0, 32'h00000000},
			'{8'h41,     1'b1, 1'b0, 3'd0, 32'h00000000},
			'{CH_BSLASH, 1'b1, 1'b1, 3'd1, 32'h20000000},
			'{CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h31,     1'b0, 1'b1, 3'd0, 32'h00000000},
			'{8'h32,     1'b1, 1'b1, 3'd3, 32'h20313200}
		};

		hold_state = PEND_NONE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the first idling mix.
		send_idle_pct = 20;
		recv_stall_pct = 53;
		for (i = 0; i < NumDirected; i++) begin
			w.in_byte = dir_tab[i].in_byte;
			w.in_last = dir_tab[i].in_last;
			send_word(w);
			if (w.in_last)
				n_strings++;
			if (dir_tab[i].typed) begin
				released.delete();
				for (k = 0; k < dir_tab[i].exp_cnt; k++) begin
					ow.out_byte = dir_tab[i].exp_bytes[31 - 8 * k -: 8];
					ow.out_last = w.in_last && (k == dir_tab[i].exp_cnt - 1);
					sanitized_q.push_back(ow);
				end
			end else begin
				queue_released();
			end
		end
		drain_wait();

		// Random strings: receiver stalls more, then sender idles more, then neither.
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 53 : 0;
			recv_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 20 : 0;
			start_items = n_items;
			while (n_items - start_items < PhaseItems) begin
				build_string();
				for (i = 0; i < str_bytes.size(); i++) begin
					w.in_byte = str_bytes[i];
					w.in_last = (i == str_bytes.size() - 1);
					send_word(w);
					queue_released();
				end
				n_strings++;
				if ($urandom_range(0, 19) == 0)
					drain_wait();
			end
			drain_wait();
		end

		// All stimulus taken: let the pipeline settle and catch stray words.
		src_valid <= 1'b0;
		repeat (16) @(posedge clk);
		if (sanitized_q.size() != 0) begin
			$display("%0t: %0d expected words never came out", $time, sanitized_q.size());
			n_fail++;
		end
		$display("Ran %0d strings, %0d bytes in, %0d words out, %0d full drains.",
			n_strings, n_items, n_words, n_drains);
		$display("Escapes kept whole: %0d; backslashes turned into spaces: %0d.",
			n_kept_esc, n_replaced);
		if (n_fail == 0)
			$display("tb_octal_escape_sanitizer_unit: PASS");
		else
			$display("tb_octal_escape_sanitizer_unit: FAIL");
		$finish;
	end

endmodule
